/* design/aet_pkg.sv */
`default_nettype none

package aet_pkg;

  localparam int LEN_BITS = 16;
  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
  localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
  localparam logic [LEN_BITS-1:0] LEN_ZERO = '0;

  typedef enum logic [3:0] {
    KIND_PLUS   = 4'd0,
    KIND_MINUS  = 4'd1,
    KIND_STAR   = 4'd2,
    KIND_SLASH  = 4'd3,
    KIND_LPAREN = 4'd4,
    KIND_RPAREN = 4'd5,
    KIND_INT    = 4'd6,
    KIND_DEC    = 4'd7,
    KIND_EOF    = 4'd8,
    KIND_ERROR  = 4'd9
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_INVALID = 2'd1,
    ERR_UNTERM  = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    MODE_IDLE       = 4'd0,
    MODE_SLASH      = 4'd1,
    MODE_INT        = 4'd2,
    MODE_INT_DOT    = 4'd3,
    MODE_DEC        = 4'd4,
    MODE_LINE_CMT   = 4'd5,
    MODE_BLOCK_CMT  = 4'd6,
    MODE_BLOCK_STAR = 4'd7,
    MODE_STOPPED    = 4'd8
  } mode_t;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

endpackage

`default_nettype wire

/* design/aet_if.sv */
`default_nettype none

interface aet_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;

  modport source (output valid, ch, end_of_source, input ready);
  modport sink (input valid, ch, end_of_source, output ready);
endinterface

interface aet_out_if #(
  parameter int OFFSET_BITS   = 24,
  parameter int LINE_COL_BITS = 16
);
  import aet_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [3:0]               token_kind;
  logic [1:0]               error_code;
  logic [7:0]               bad_char;
  logic [LINE_COL_BITS-1:0] tok_line;
  logic [LINE_COL_BITS-1:0] tok_column;
  logic [OFFSET_BITS-1:0]   tok_offset;
  logic [LEN_BITS-1:0]      tok_length;
  logic                     last_of_run;

  modport source (output valid, token_kind, error_code, bad_char, tok_line, tok_column,
                  tok_offset, tok_length, last_of_run, input ready);
  modport sink (input valid, token_kind, error_code, bad_char, tok_line, tok_column,
                tok_offset, tok_length, last_of_run, output ready);
endinterface

`default_nettype wire

/* design/aet_scan.sv */
`default_nettype none

module aet_scan #(
  parameter int OFFSET_BITS   = 24,
  parameter int LINE_COL_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] ch,
  input  wire logic       eos,
  output logic [1:0]      n_res,
  output logic [4+2+8+2*LINE_COL_BITS+OFFSET_BITS+aet_pkg::LEN_BITS:0] res0,
  output logic [4+2+8+2*LINE_COL_BITS+OFFSET_BITS+aet_pkg::LEN_BITS:0] res1
);
  import aet_pkg::*;

  localparam int LC  = LINE_COL_BITS;
  localparam int OFF = OFFSET_BITS;
  localparam int DW  = (OFF > LEN_BITS) ? OFF : LEN_BITS;

  typedef struct packed {
    logic [3:0]          token_kind;
    logic [1:0]          error_code;
    logic [7:0]          bad_char;
    logic [LC-1:0]       tok_line;
    logic [LC-1:0]       tok_column;
    logic [OFF-1:0]      tok_offset;
    logic [LEN_BITS-1:0] tok_length;
    logic                last_of_run;
  } res_t;

  function automatic res_t mk(kind_t k, err_t e, logic [7:0] b, logic [LC-1:0] ln,
                              logic [LC-1:0] cl, logic [OFF-1:0] of,
                              logic [LEN_BITS-1:0] len);
    res_t r;
    r.token_kind  = k;
    r.error_code  = e;
    r.bad_char    = b;
    r.tok_line    = ln;
    r.tok_column  = cl;
    r.tok_offset  = of;
    r.tok_length  = len;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  mode_t          mode_r, mode_nxt;
  logic [LC-1:0]  cur_line_r, cur_col_r, st_line_r, st_col_r;
  logic [OFF-1:0] cur_off_r, st_off_r;

  // character classes
  logic  is_ws, is_dig, is_slash, is_star, is_dot, is_nl, op_valid;
  kind_t op_kind;

  always_comb begin
    is_nl    = (ch == CH_NL);
    is_ws    = (ch == CH_SPACE) || (ch == CH_TAB) || is_nl || (ch == CH_CR);
    is_dig   = (ch >= CH_0) && (ch <= CH_9);
    is_slash = (ch == CH_SLASH);
    is_star  = (ch == CH_STAR);
    is_dot   = (ch == CH_DOT);
    op_valid = 1'b1;
    unique case (ch)
      CH_PLUS:   op_kind = KIND_PLUS;
      CH_MINUS:  op_kind = KIND_MINUS;
      CH_STAR:   op_kind = KIND_STAR;
      CH_LPAREN: op_kind = KIND_LPAREN;
      CH_RPAREN: op_kind = KIND_RPAREN;
      default: begin
        op_kind  = KIND_PLUS;
        op_valid = 1'b0;
      end
    endcase
  end

  // positions after consuming one byte, or a '.' and then a digit
  logic [LC-1:0]  line_inc, col_inc, col2, line1, col1;
  logic [OFF-1:0] off_inc, off2;
  logic [DW-1:0]  pend_diff;
  logic [LEN_BITS-1:0] pend_len;

  always_comb begin
    line_inc  = (&cur_line_r) ? cur_line_r : cur_line_r + LC'(1);
    col_inc   = (&cur_col_r) ? cur_col_r : cur_col_r + LC'(1);
    col2      = (&col_inc) ? col_inc : col_inc + LC'(1);
    off_inc   = (&cur_off_r) ? cur_off_r : cur_off_r + OFF'(1);
    off2      = (&off_inc) ? off_inc : off_inc + OFF'(1);
    line1     = is_nl ? line_inc : cur_line_r;
    col1      = is_nl ? LC'(1) : col_inc;
    pend_diff = DW'(cur_off_r - st_off_r);
    pend_len  = (pend_diff > DW'(LEN_MAX)) ? LEN_MAX : pend_diff[LEN_BITS-1:0];
  end

  mode_t idle_mode;

  // next scan mode
  always_comb begin
    if (is_dig)                idle_mode = MODE_INT;
    else if (is_slash)         idle_mode = MODE_SLASH;
    else if (is_ws || op_valid) idle_mode = MODE_IDLE;
    else                       idle_mode = MODE_STOPPED;

    mode_nxt = mode_r;
    if (eos) begin
      unique case (mode_r)
        MODE_INT_DOT, MODE_BLOCK_CMT, MODE_BLOCK_STAR, MODE_STOPPED: mode_nxt = MODE_STOPPED;
        default: mode_nxt = MODE_IDLE;
      endcase
    end else begin
      unique case (mode_r)
        MODE_IDLE: mode_nxt = idle_mode;
        MODE_SLASH: begin
          if (is_slash)     mode_nxt = MODE_LINE_CMT;
          else if (is_star) mode_nxt = MODE_BLOCK_CMT;
          else              mode_nxt = idle_mode;
        end
        MODE_INT: begin
          if (is_dig)      mode_nxt = MODE_INT;
          else if (is_dot) mode_nxt = MODE_INT_DOT;
          else             mode_nxt = idle_mode;
        end
        MODE_INT_DOT:   mode_nxt = is_dig ? MODE_DEC : MODE_STOPPED;
        MODE_DEC:       mode_nxt = is_dig ? MODE_DEC : idle_mode;
        MODE_LINE_CMT:  mode_nxt = is_nl ? MODE_IDLE : MODE_LINE_CMT;
        MODE_BLOCK_CMT: mode_nxt = is_star ? MODE_BLOCK_STAR : MODE_BLOCK_CMT;
        MODE_BLOCK_STAR: begin
          if (is_slash)     mode_nxt = MODE_IDLE;
          else if (is_star) mode_nxt = MODE_BLOCK_STAR;
          else              mode_nxt = MODE_BLOCK_CMT;
        end
        default: mode_nxt = MODE_STOPPED;
      endcase
    end
  end

  // results and position actions
  logic  cons_c, cons_dd, mark, clr, flush, take_idle, idle_emit;
  kind_t flush_kind;
  res_t  r0, r1, idle_res, eof_res, dot_res;

  always_comb begin
    idle_emit = !(is_ws || is_dig || is_slash);
    idle_res  = op_valid ?
                mk(op_kind, ERR_NONE, 8'd0, cur_line_r, cur_col_r, cur_off_r, LEN_ONE) :
                mk(KIND_ERROR, ERR_INVALID, ch, cur_line_r, cur_col_r, cur_off_r, LEN_ONE);
    eof_res   = mk(KIND_EOF, ERR_NONE, 8'd0, cur_line_r, cur_col_r, cur_off_r, LEN_ZERO);
    dot_res   = mk(KIND_ERROR, ERR_INVALID, CH_DOT, cur_line_r, cur_col_r, cur_off_r,
                   LEN_ONE);

    n_res      = 2'd0;
    r0         = '0;
    r1         = '0;
    cons_c     = 1'b0;
    cons_dd    = 1'b0;
    mark       = 1'b0;
    clr        = 1'b0;
    flush      = 1'b0;
    take_idle  = 1'b0;
    flush_kind = KIND_INT;

    if (eos) begin
      unique case (mode_r)
        MODE_SLASH, MODE_INT, MODE_DEC: begin
          if (mode_r == MODE_SLASH)    flush_kind = KIND_SLASH;
          else if (mode_r == MODE_DEC) flush_kind = KIND_DEC;
          else                         flush_kind = KIND_INT;
          r0    = mk(flush_kind, ERR_NONE, 8'd0, st_line_r, st_col_r, st_off_r, pend_len);
          r1    = eof_res;
          n_res = 2'd2;
          clr   = 1'b1;
        end
        MODE_INT_DOT: begin
          r0    = mk(KIND_INT, ERR_NONE, 8'd0, st_line_r, st_col_r, st_off_r, pend_len);
          r1    = dot_res;
          n_res = 2'd2;
        end
        MODE_BLOCK_CMT, MODE_BLOCK_STAR: begin
          r0    = mk(KIND_ERROR, ERR_UNTERM, 8'd0, st_line_r, st_col_r, st_off_r, pend_len);
          n_res = 2'd1;
        end
        MODE_IDLE, MODE_LINE_CMT: begin
          r0    = eof_res;
          n_res = 2'd1;
          clr   = 1'b1;
        end
        default: ;
      endcase
    end else begin
      unique case (mode_r)
        MODE_IDLE: take_idle = 1'b1;
        MODE_SLASH: begin
          if (is_slash || is_star) begin
            cons_c = 1'b1;
          end else begin
            flush      = 1'b1;
            flush_kind = KIND_SLASH;
            take_idle  = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_dig) begin
            cons_c = 1'b1;
          end else if (!is_dot) begin
            flush     = 1'b1;
            take_idle = 1'b1;
          end
        end
        MODE_INT_DOT: begin
          if (is_dig) begin
            cons_dd = 1'b1;
          end else begin
            r0    = mk(KIND_INT, ERR_NONE, 8'd0, st_line_r, st_col_r, st_off_r, pend_len);
            r1    = dot_res;
            n_res = 2'd2;
          end
        end
        MODE_DEC: begin
          if (is_dig) begin
            cons_c = 1'b1;
          end else begin
            flush      = 1'b1;
            flush_kind = KIND_DEC;
            take_idle  = 1'b1;
          end
        end
        MODE_LINE_CMT, MODE_BLOCK_CMT, MODE_BLOCK_STAR: cons_c = 1'b1;
        default: ;
      endcase
    end

    if (take_idle) begin
      cons_c = is_ws || is_dig || is_slash || op_valid;
      mark   = is_dig || is_slash;
    end

    if (flush) begin
      r0 = mk(flush_kind, ERR_NONE, 8'd0, st_line_r, st_col_r, st_off_r, pend_len);
      if (idle_emit) begin
        r1    = idle_res;
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
      end
    end else if (take_idle && idle_emit) begin
      r0    = idle_res;
      n_res = 2'd1;
    end

    if (n_res == 2'd1) r0.last_of_run = 1'b1;
    if (n_res == 2'd2) r1.last_of_run = 1'b1;

    res0 = r0;
    res1 = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      cur_line_r <= LC'(1);
      cur_col_r  <= LC'(1);
      cur_off_r  <= '0;
      st_line_r  <= LC'(1);
      st_col_r   <= LC'(1);
      st_off_r   <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      if (clr) begin
        cur_line_r <= LC'(1);
        cur_col_r  <= LC'(1);
        cur_off_r  <= '0;
        st_line_r  <= LC'(1);
        st_col_r   <= LC'(1);
        st_off_r   <= '0;
      end else begin
        if (cons_c) begin
          cur_line_r <= line1;
          cur_col_r  <= col1;
          cur_off_r  <= off_inc;
        end else if (cons_dd) begin
          cur_col_r <= col2;
          cur_off_r <= off2;
        end
        if (mark) begin
          st_line_r <= cur_line_r;
          st_col_r  <= cur_col_r;
          st_off_r  <= cur_off_r;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/aet_rq.sv */
`default_nettype none

module aet_rq #(
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        push_cnt,
  input  wire logic [DATA_W-1:0] din0,
  input  wire logic [DATA_W-1:0] din1,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      dout
);

  localparam int DEPTH = 4;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [1:0]        wr_ptr_r, rd_ptr_r;
  logic [2:0]        cnt_r;
  logic              pop;

  assign room      = (cnt_r <= 3'(DEPTH - 2));
  assign out_valid = (cnt_r != 3'd0);
  assign dout      = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= din0;
    if (push_cnt == 2'd2) mem_r[wr_ptr_r + 2'd1] <= din1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push_cnt;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + 3'(push_cnt) - 3'(pop);
    end
  end

endmodule

`default_nettype wire

/* design/arith_expression_tokenizer.sv */
`default_nettype none

// Channel   Dir  Fields                                              Handshake
// in_chan   in   ch, end_of_source                                   valid/ready
// out_chan  out  token_kind, error_code, bad_char, tok_line,         valid/ready
//                tok_column, tok_offset, tok_length, last_of_run
//
// One request per cycle while in_chan.ready is high: the scanner state updates in the
// cycle a request is taken. A request yields 0, 1 or 2 tokens into a 4-entry result
// queue; two tokens from one request leave it in turn. in_chan.ready falls while the
// queue holds more than two tokens. Synchronous active-low reset returns the scanner to
// line 1, column 1, offset 0; after an error, requests are taken but give no token.

module arith_expression_tokenizer #(
  parameter int OFFSET_BITS   = 24,
  parameter int LINE_COL_BITS = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  aet_in_if.sink    in_chan,
  aet_out_if.source out_chan
);
  import aet_pkg::*;

  localparam int LC  = LINE_COL_BITS;
  localparam int OFF = OFFSET_BITS;

  typedef struct packed {
    logic [3:0]          token_kind;
    logic [1:0]          error_code;
    logic [7:0]          bad_char;
    logic [LC-1:0]       tok_line;
    logic [LC-1:0]       tok_column;
    logic [OFF-1:0]      tok_offset;
    logic [LEN_BITS-1:0] tok_length;
    logic                last_of_run;
  } res_t;

  localparam int RES_W = $bits(res_t);

  logic             acc, room;
  logic [1:0]       n_res, push_cnt;
  logic [RES_W-1:0] res0, res1, q_dout;
  res_t             q_res;

  assign in_chan.ready = room;
  assign acc           = in_chan.valid && room;
  assign push_cnt      = acc ? n_res : 2'd0;

  aet_scan #(
    .OFFSET_BITS   (OFF),
    .LINE_COL_BITS (LC)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .ch    (in_chan.ch),
    .eos   (in_chan.end_of_source),
    .n_res (n_res),
    .res0  (res0),
    .res1  (res1)
  );

  aet_rq #(
    .DATA_W (RES_W)
  ) u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .din0      (res0),
    .din1      (res1),
    .room      (room),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .dout      (q_dout)
  );

  assign q_res               = q_dout;
  assign out_chan.token_kind  = q_res.token_kind;
  assign out_chan.error_code  = q_res.error_code;
  assign out_chan.bad_char    = q_res.bad_char;
  assign out_chan.tok_line    = q_res.tok_line;
  assign out_chan.tok_column  = q_res.tok_column;
  assign out_chan.tok_offset  = q_res.tok_offset;
  assign out_chan.tok_length  = q_res.tok_length;
  assign out_chan.last_of_run = q_res.last_of_run;

endmodule

`default_nettype wire

/* test/arith_expression_tokenizer_tb.sv */
`timescale 1ns / 100ps

module arith_expression_tokenizer_tb;
  import aet_pkg::*;

  localparam int OFF_W = 24;
  localparam int LC_W = 16;
  localparam int RANDOM_REQS = 950;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [7:0] ch;
    logic       eos;
  } src_req_t;

  typedef struct {
    kind_t               kind;
    err_t                err;
    logic [7:0]          bad;
    logic [LC_W-1:0]     line;
    logic [LC_W-1:0]     column;
    logic [OFF_W-1:0]    offset;
    logic [LEN_BITS-1:0] length;
    logic                last;
  } token_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  aet_in_if in_chan ();
  aet_out_if #(.OFFSET_BITS(OFF_W), .LINE_COL_BITS(LC_W)) out_chan ();

  arith_expression_tokenizer #(
    .OFFSET_BITS(OFF_W),
    .LINE_COL_BITS(LC_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan)
  );

  always #6 clk = ~clk;

  src_req_t source_reqs[$];
  token_t   expected_tokens[$];
  token_t   tok_buf[2];
  token_t   head_tok;
  int       n_tok;
  int       fail_count = 0;
  int       reqs_taken = 0;
  int       phase_len = 1;
  int       stall_cycles = 0;
  int       send_gap;
  int       recv_stall;
  logic     req_taken = 1'b0;
  logic     progress;

  // scanner state
  mode_t               lex_mode;
  logic [LC_W-1:0]     cur_line, cur_col, start_line, start_col;
  logic [OFF_W-1:0]    cur_off, start_off;

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  task automatic reset_scan();
    lex_mode = MODE_IDLE;
    cur_line = LC_W'(1);
    cur_col = LC_W'(1);
    cur_off = '0;
    start_line = LC_W'(1);
    start_col = LC_W'(1);
    start_off = '0;
  endtask

  task automatic advance(logic [7:0] c);
    if (c == CH_NL) begin
      if (cur_line != '1) cur_line = cur_line + 1'b1;
      cur_col = LC_W'(1);
    end else if (cur_col != '1) begin
      cur_col = cur_col + 1'b1;
    end
    if (cur_off != '1) cur_off = cur_off + 1'b1;
  endtask

  function automatic logic [LEN_BITS-1:0] span_len();
    logic [OFF_W-1:0] d;
    d = (cur_off >= start_off) ? cur_off - start_off : '0;
    if (d > OFF_W'(LEN_MAX)) return LEN_MAX;
    return d[LEN_BITS-1:0];
  endfunction

  task automatic put_token(kind_t k, err_t e, logic [7:0] b, logic [LC_W-1:0] ln,
                           logic [LC_W-1:0] cl, logic [OFF_W-1:0] of,
                           logic [LEN_BITS-1:0] len);
    tok_buf[1'(n_tok)] = '{k, e, b, ln, cl, of, len, 1'b0};
    n_tok++;
  endtask

  task automatic emit_span(kind_t k);
    put_token(k, ERR_NONE, 8'h00, start_line, start_col, start_off, span_len());
  endtask

  // bad byte is not consumed; scanner stops
  task automatic flag_bad(logic [7:0] c);
    put_token(KIND_ERROR, ERR_INVALID, c, cur_line, cur_col, cur_off, LEN_ONE);
    lex_mode = MODE_STOPPED;
  endtask

  task automatic idle_byte(logic [7:0] c);
    kind_t k;
    if (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_CR) begin
      advance(c);
      return;
    end
    if (is_digit(c) || c == CH_SLASH) begin
      start_line = cur_line;
      start_col = cur_col;
      start_off = cur_off;
      advance(c);
      if (c == CH_SLASH) lex_mode = MODE_SLASH;
      else lex_mode = MODE_INT;
      return;
    end
    case (c)
      CH_PLUS: k = KIND_PLUS;
      CH_MINUS: k = KIND_MINUS;
      CH_STAR: k = KIND_STAR;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      default: begin
        flag_bad(c);
        return;
      end
    endcase
    put_token(k, ERR_NONE, 8'h00, cur_line, cur_col, cur_off, LEN_ONE);
    advance(c);
  endtask

  task automatic finish_source();
    case (lex_mode)
      MODE_SLASH: emit_span(KIND_SLASH);
      MODE_INT: emit_span(KIND_INT);
      MODE_DEC: emit_span(KIND_DEC);
      MODE_INT_DOT: begin
        emit_span(KIND_INT);
        flag_bad(CH_DOT);
        return;
      end
      MODE_BLOCK_CMT, MODE_BLOCK_STAR: begin
        put_token(KIND_ERROR, ERR_UNTERM, 8'h00, start_line, start_col, start_off,
                  span_len());
        lex_mode = MODE_STOPPED;
        return;
      end
      default: ;
    endcase
    put_token(KIND_EOF, ERR_NONE, 8'h00, cur_line, cur_col, cur_off, LEN_ZERO);
    reset_scan();
  endtask

  task automatic scan_request(logic [7:0] c, logic eos);
    n_tok = 0;
    if (lex_mode == MODE_STOPPED) return;
    if (eos) begin
      finish_source();
    end else begin
      case (lex_mode)
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            advance(c);
            lex_mode = MODE_LINE_CMT;
          end else if (c == CH_STAR) begin
            advance(c);
            lex_mode = MODE_BLOCK_CMT;
          end else begin
            emit_span(KIND_SLASH);
            lex_mode = MODE_IDLE;
            idle_byte(c);
          end
        end
        MODE_INT: begin
          if (is_digit(c)) begin
            advance(c);
          end else if (c == CH_DOT) begin
            lex_mode = MODE_INT_DOT;  // dot not counted until resolved
          end else begin
            emit_span(KIND_INT);
            lex_mode = MODE_IDLE;
            idle_byte(c);
          end
        end
        MODE_INT_DOT: begin
          if (is_digit(c)) begin
            advance(CH_DOT);
            advance(c);
            lex_mode = MODE_DEC;
          end else begin
            emit_span(KIND_INT);
            flag_bad(CH_DOT);
          end
        end
        MODE_DEC: begin
          if (is_digit(c)) begin
            advance(c);
          end else begin
            emit_span(KIND_DEC);
            lex_mode = MODE_IDLE;
            idle_byte(c);
          end
        end
        MODE_LINE_CMT: begin
          advance(c);
          if (c == CH_NL) lex_mode = MODE_IDLE;
        end
        MODE_BLOCK_CMT: begin
          advance(c);
          if (c == CH_STAR) lex_mode = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          advance(c);
          if (c == CH_SLASH) lex_mode = MODE_IDLE;
          else if (c != CH_STAR) lex_mode = MODE_BLOCK_CMT;
        end
        default: begin
          lex_mode = MODE_IDLE;
          idle_byte(c);
        end
      endcase
    end
    if (n_tok > 0) begin
      tok_buf[1'(n_tok - 1)].last = 1'b1;
      for (int i = 0; i < n_tok; i++)
        expected_tokens.insert(expected_tokens.size(), tok_buf[1'(i)]);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------- stimulus builders ----------------

  task automatic queue_req(logic [7:0] b, logic eos);
    src_req_t r;
    r.ch = b;
    r.eos = eos;
    source_reqs.insert(source_reqs.size(), r);
  endtask

  task automatic add_byte(logic [7:0] b);
    queue_req(b, 1'b0);
  endtask

  task automatic add_eos();
    queue_req(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_digits(int n);
    for (int i = 0; i < n; i++) add_byte(8'(CH_0 + $urandom_range(0, 9)));
  endtask

  // body never closes early; any byte may appear, newlines included
  task automatic add_block_comment(int body_len, logic closed);
    logic [7:0] b, prev;
    add_text("/*");
    prev = 8'h00;
    for (int i = 0; i < body_len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (prev == CH_STAR && b == CH_SLASH) b = CH_DOT;
      add_byte(b);
      prev = b;
    end
    if (closed) add_text("*/");
  endtask

  task automatic add_line_comment(int body_len);
    logic [7:0] b;
    add_text("//");
    for (int i = 0; i < body_len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_NL) b = CH_CR;
      add_byte(b);
    end
  endtask

  task automatic add_random_source();
    logic [7:0] ops[6];
    logic [7:0] op;
    logic slash_last, dec_open;
    int pieces;
    ops = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN};
    pieces = $urandom_range(0, 12);
    slash_last = 1'b0;
    dec_open = 1'b0;
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          add_digits($urandom_range(1, 4));
          slash_last = 1'b0;
        end
        2: begin
          // a second dot right after a decimal would be a stray character
          if (dec_open) add_byte(CH_SPACE);
          add_digits($urandom_range(1, 3));
          add_byte(CH_DOT);
          add_digits($urandom_range(1, 3));
          dec_open = 1'b1;
          slash_last = 1'b0;
        end
        3, 4, 5: begin
          op = ops[3'($urandom_range(0, 5))];
          if (slash_last && (op == CH_SLASH || op == CH_STAR)) add_byte(CH_SPACE);
          add_byte(op);
          slash_last = (op == CH_SLASH);
          dec_open = 1'b0;
        end
        6, 7: begin
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
              0: add_byte(CH_SPACE);
              1: add_byte(CH_TAB);
              2: add_byte(CH_CR);
              default: add_byte(CH_NL);
            endcase
          end
          slash_last = 1'b0;
          dec_open = 1'b0;
        end
        8: begin
          if (slash_last) add_byte(CH_SPACE);
          add_line_comment($urandom_range(0, 6));
          add_byte(CH_NL);
          slash_last = 1'b0;
          dec_open = 1'b0;
        end
        default: begin
          if (slash_last) add_byte(CH_SPACE);
          add_block_comment($urandom_range(0, 6), 1'b1);
          slash_last = 1'b0;
          dec_open = 1'b0;
        end
      endcase
    end
    // end of source inside a line comment
    if ($urandom_range(0, 7) == 0) begin
      if (slash_last) add_byte(CH_SPACE);
      add_line_comment($urandom_range(0, 4));
    end
    add_eos();
  endtask

  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (is_digit(b) || b inside {CH_SPACE, CH_TAB, CH_NL, CH_CR, CH_PLUS, CH_MINUS,
                                    CH_STAR, CH_LPAREN, CH_RPAREN, CH_SLASH})
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // ---------------- driver ----------------

  always @(negedge clk) begin
    case (reqs_taken / phase_len)
      0: begin
        send_gap = 15;
        recv_stall = 56;
      end
      1: begin
        send_gap = 56;
        recv_stall = 15;
      end
      default: begin
        send_gap = 0;
        recv_stall = 0;
      end
    endcase
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.ch <= 8'h00;
      in_chan.end_of_source <= 1'b0;
    end else if (!in_chan.valid || req_taken) begin
      if (source_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap) begin
        in_chan.valid <= 1'b1;
        in_chan.ch <= source_reqs[0].ch;
        in_chan.end_of_source <= source_reqs[0].eos;
        void'(source_reqs.pop_front());
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
    out_chan.ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // ---------------- monitor, predictor, watchdog ----------------

  always @(posedge clk) begin
    req_taken = 1'b0;
    progress = 1'b0;
    if (!rst_n) begin
      reset_scan();
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        scan_request(in_chan.ch, in_chan.end_of_source);
        reqs_taken++;
        req_taken = 1'b1;
        progress = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        progress = 1'b1;
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d at offset %0d", out_chan.token_kind,
                 out_chan.tok_offset);
          fail_count++;
        end else begin
          head_tok = expected_tokens.pop_front();
          check_field("token_kind", 32'(head_tok.kind), 32'(out_chan.token_kind));
          check_field("error_code", 32'(head_tok.err), 32'(out_chan.error_code));
          check_field("bad_char", 32'(head_tok.bad), 32'(out_chan.bad_char));
          check_field("tok_line", 32'(head_tok.line), 32'(out_chan.tok_line));
          check_field("tok_column", 32'(head_tok.column), 32'(out_chan.tok_column));
          check_field("tok_offset", 32'(head_tok.offset), 32'(out_chan.tok_offset));
          check_field("tok_length", 32'(head_tok.length), 32'(out_chan.tok_length));
          check_field("last_of_run", 32'(head_tok.last), 32'(out_chan.last_of_run));
        end
      end
      if (progress) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    // every operator, slash held to end of source
    add_text("+-*()/");
    add_eos();
    // decimal, slash-star-slash stays open, slash before a digit, line comment
    add_text("0.9/*/");
    add_byte(8'h80);
    add_text("**/ 12/3\t//");
    add_byte(8'hFF);
    add_byte(CH_NL);
    add_eos();

    while (source_reqs.size() < RANDOM_REQS - 20) add_random_source();
    phase_len = (source_reqs.size() + 2) / 3;

    add_text("31+");
    add_eos();

    // one terminal error, then requests that must give nothing
    case ($urandom_range(0, 3))
      0: begin
        add_text("4+");
        add_byte(stray_byte());
      end
      1: begin
        add_text("(56.");
        add_byte(8'($urandom_range(0, 255)) & 8'hEF);  // clears bit 4: never a digit
      end
      2: begin
        add_text("7.");
        add_eos();
      end
      default: begin
        add_text("1 ");
        add_block_comment($urandom_range(0, 8), 1'b0);
        add_eos();
      end
    endcase
    repeat (8) queue_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (source_reqs.size() != 0 || in_chan.valid) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
